/* rtl/core/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared beat type, item kind codes, parser phase codes and header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] KIND_ABSORBED = 2'd0;
   localparam logic [1:0] KIND_HEADER   = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd2;

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [6:0] LEN16_CODE  = 7'd126;
   localparam logic [6:0] LEN64_CODE  = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] length;
      logic [7:0]  data;
      logic [7:0]  key;
      logic        frame_end;
   } beat_type;

endpackage

`default_nettype wire

/* rtl/core/wsd_front.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses the frame header byte by byte and classifies every input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_data_byte,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output wsd_pkg::beat_type     push_beat
);
   import wsd_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        long_ff, long_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [1:0]  key_idx_ff, key_idx_in;
   logic        fire;
   logic        len_done;
   logic        hdr_done;
   logic [7:0]  key_byte;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign fire       = req_valid && push_ready;

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      long_in      = long_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      length_in    = length_ff;
      key_in       = key_ff;
      remaining_in = remaining_ff;
      key_idx_in   = key_idx_ff;
      len_done     = 1'b0;
      hdr_done     = 1'b0;
      push_beat    = '0;
      push_beat.kind = KIND_ABSORBED;
      case (phase_ff)
         PH_SECOND: begin
            masked_in = req_data_byte[7];
            length_in = '0;
            key_in    = '0;
            count_in  = '0;
            if (req_data_byte[6:0] == LEN16_CODE) begin
               long_in  = 1'b0;
               phase_in = PH_EXTLEN;
            end else if (req_data_byte[6:0] == LEN64_CODE) begin
               long_in  = 1'b1;
               phase_in = PH_EXTLEN;
            end else begin
               length_in = {57'd0, req_data_byte[6:0]};
               len_done  = 1'b1;
            end
         end
         PH_EXTLEN: begin
            length_in = {length_ff[55:0], req_data_byte};
            count_in  = count_ff + 4'd1;
            if (count_in == (long_ff ? EXT64_BYTES : EXT16_BYTES)) begin
               len_done = 1'b1;
            end
         end
         PH_KEY: begin
            key_in   = {key_ff[23:0], req_data_byte};
            count_in = count_ff + 4'd1;
            if (count_in == KEY_BYTES) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            key_idx_in          = key_idx_ff + 2'd1;
            remaining_in        = remaining_ff - 64'd1;
            push_beat.kind      = KIND_PAYLOAD;
            push_beat.fin       = fin_ff;
            push_beat.opcode    = opcode_ff;
            push_beat.masked    = masked_ff;
            push_beat.length    = length_ff;
            push_beat.data      = req_data_byte;
            push_beat.key       = masked_ff ? key_byte : 8'd0;
            push_beat.frame_end = (remaining_ff == 64'd1);
            if (remaining_ff == 64'd1) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            fin_in    = req_data_byte[7];
            opcode_in = req_data_byte[3:0];
            masked_in = 1'b0;
            length_in = '0;
            key_in    = '0;
            count_in  = '0;
            phase_in  = PH_SECOND;
         end
      endcase
      if (len_done) begin
         count_in = '0;
         if (masked_in) begin
            phase_in = PH_KEY;
         end else begin
            hdr_done = 1'b1;
         end
      end
      if (hdr_done) begin
         remaining_in        = length_in;
         key_idx_in          = '0;
         count_in            = '0;
         phase_in            = (length_in == 64'd0) ? PH_FIRST : PH_PAYLOAD;
         push_beat.kind      = KIND_HEADER;
         push_beat.fin       = fin_in;
         push_beat.opcode    = opcode_in;
         push_beat.masked    = masked_in;
         push_beat.length    = length_in;
         push_beat.frame_end = (length_in == 64'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         count_ff     <= '0;
         long_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         masked_ff    <= 1'b0;
         length_ff    <= '0;
         key_ff       <= '0;
         remaining_ff <= '0;
         key_idx_ff   <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         long_ff      <= long_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         length_ff    <= length_in;
         key_ff       <= key_in;
         remaining_ff <= remaining_in;
         key_idx_ff   <= key_idx_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/wsd_queue.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer beat queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_queue #(
   parameter int Depth = wsd_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire wsd_pkg::beat_type push_beat,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output wsd_pkg::beat_type      pop_beat
);
   import wsd_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   beat_type              mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_beat   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/wsd_back.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Unmasks payload bytes and holds each result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire wsd_pkg::beat_type pop_beat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_item_kind,
   output logic                   rsp_fin_flag,
   output logic [3:0]             rsp_frame_opcode,
   output logic                   rsp_masked_flag,
   output logic [63:0]            rsp_frame_length,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_frame_end
);
   import wsd_pkg::*;

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic        fin_ff;
   logic [3:0]  opcode_ff;
   logic        masked_ff;
   logic [63:0] length_ff;
   logic [7:0]  byte_ff;
   logic        end_ff;
   logic        load;

   assign pop_ready = !valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= pop_beat.kind;
         fin_ff    <= pop_beat.fin;
         opcode_ff <= pop_beat.opcode;
         masked_ff <= pop_beat.masked;
         length_ff <= pop_beat.length;
         byte_ff   <= pop_beat.data ^ pop_beat.key;
         end_ff    <= pop_beat.frame_end;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_item_kind    = kind_ff;
   assign rsp_fin_flag     = fin_ff;
   assign rsp_frame_opcode = opcode_ff;
   assign rsp_masked_flag  = masked_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_frame_end    = end_ff;

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer_unit.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser and unmasker, one byte beat per clock unless stalled.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock while the queue has room and
// returns exactly one result beat per byte, via the queue and output register.
// With the output side not stalled, the sustained rate is one byte per cycle,
// set by the parser state update in the front end, which is combinational.
// A small queue and the output register let the input keep flowing while a
// result waits to be taken; there is no start-up clearing pass.
`default_nettype none

module websocket_frame_deframer_unit #(
   parameter int QueueDepth = wsd_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_item_kind,
   output logic             rsp_fin_flag,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_masked_flag,
   output logic [63:0]      rsp_frame_length,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_frame_end
);
   import wsd_pkg::*;

   logic     push_valid;
   logic     push_ready;
   beat_type push_beat;
   logic     pop_valid;
   logic     pop_ready;
   beat_type pop_beat;

   wsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_beat     (push_beat)
   );

   wsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_beat  (push_beat),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_beat   (pop_beat)
   );

   wsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_beat         (pop_beat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_fin_flag     (rsp_fin_flag),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_masked_flag  (rsp_masked_flag),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

`default_nettype wire

/* rtl/core/wsd_checker.sv */
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level assertions on the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_item_kind,
   input wire logic        rsp_fin_flag,
   input wire logic [3:0]  rsp_frame_opcode,
   input wire logic        rsp_masked_flag,
   input wire logic [63:0] rsp_frame_length,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic        rsp_frame_end
);
   import wsd_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_frame_end)
         && $stable(rsp_frame_length))
      else $error("stalled result beat changed");

   a_absorbed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_ABSORBED |-> !rsp_fin_flag
         && rsp_frame_opcode == 4'd0 && !rsp_masked_flag
         && rsp_frame_length == 64'd0 && rsp_payload_byte == 8'd0 && !rsp_frame_end)
      else $error("absorbed header beat carries nonzero fields");

   a_header_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_HEADER |-> rsp_payload_byte == 8'd0
         && (rsp_frame_end == (rsp_frame_length == 64'd0)))
      else $error("header beat has wrong frame end or payload byte");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item_kind == KIND_ABSORBED || rsp_item_kind == KIND_HEADER
         || rsp_item_kind == KIND_PAYLOAD)
      else $error("result beat has an undefined kind");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_checker (.*);

`default_nettype wire

/* sim/tb_websocket_frame_deframer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds a directed table and then random well-formed frame streams into the
// deframer, with random idle bursts on both channels. Every result beat is
// compared field by field against a typed row or a behavioral frame parser model.
// ----------------------------------------------------------------------------

module tb_websocket_frame_deframer_unit;

   import wsd_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] length;
      logic [7:0]  data;
      logic        frame_end;
   } deframe_beat_type;

   localparam deframe_beat_type ABSORBED_BEAT = '0;
   localparam int RANDOM_ITEMS = 950;
   localparam int CALM_ITEMS   = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_item_kind;
   logic        rsp_fin_flag;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_masked_flag;
   logic [63:0] rsp_frame_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_end;

   websocket_frame_deframer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_fin_flag     (rsp_fin_flag),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_masked_flag  (rsp_masked_flag),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Parser model state, starting from its reset values.
   logic [2:0]  p_phase     = PH_FIRST;
   logic [3:0]  p_count     = '0;
   logic        p_fin       = 1'b0;
   logic [3:0]  p_opcode    = '0;
   logic        p_masked    = 1'b0;
   logic [63:0] p_length    = '0;
   logic [31:0] p_key       = '0;
   logic [63:0] p_remaining = '0;
   logic [1:0]  p_key_idx   = '0;
   logic [3:0]  p_ext_need  = '0;

   deframe_beat_type expected_beats[$];
   deframe_beat_type cur_exp;
   bit               cur_typed;
   bit               idle_on;
   int               mismatch_count;
   int               quiet_cycles;
   int               bytes_sent;

   function automatic deframe_beat_type make_beat(input logic [1:0] kind, input logic fin,
                                                  input logic [3:0] opcode,
                                                  input logic masked,
                                                  input logic [63:0] length,
                                                  input logic [7:0] data,
                                                  input logic frame_end);
      deframe_beat_type r;
      r.kind      = kind;
      r.fin       = fin;
      r.opcode    = opcode;
      r.masked    = masked;
      r.length    = length;
      r.data      = data;
      r.frame_end = frame_end;
      return r;
   endfunction

   function automatic deframe_beat_type header_done_beat();
      deframe_beat_type r;
      p_remaining = p_length;
      p_key_idx   = '0;
      p_count     = '0;
      r = make_beat(KIND_HEADER, p_fin, p_opcode, p_masked, p_length, 8'h00,
                    p_length == 64'd0);
      p_phase = (p_length == 64'd0) ? PH_FIRST : PH_PAYLOAD;
      return r;
   endfunction

   function automatic deframe_beat_type length_known_beat();
      p_count = '0;
      if (p_masked) begin
         p_phase = PH_KEY;
         return ABSORBED_BEAT;
      end
      return header_done_beat();
   endfunction

   function automatic deframe_beat_type deframe_byte(input logic [7:0] b);
      deframe_beat_type r;
      logic [7:0]       v;
      r = ABSORBED_BEAT;
      case (p_phase)
         PH_SECOND: begin
            p_masked = b[7];
            p_length = '0;
            p_key    = '0;
            p_count  = '0;
            if (b[6:0] == LEN16_CODE) begin
               p_ext_need = EXT16_BYTES;
               p_phase    = PH_EXTLEN;
            end else if (b[6:0] == LEN64_CODE) begin
               p_ext_need = EXT64_BYTES;
               p_phase    = PH_EXTLEN;
            end else begin
               p_length = {57'd0, b[6:0]};
               r = length_known_beat();
            end
         end
         PH_EXTLEN: begin
            p_length = {p_length[55:0], b};
            p_count  = p_count + 4'd1;
            if (p_count >= p_ext_need)
               r = length_known_beat();
         end
         PH_KEY: begin
            p_key   = {p_key[23:0], b};
            p_count = p_count + 4'd1;
            if (p_count >= KEY_BYTES)
               r = header_done_beat();
         end
         PH_PAYLOAD: begin
            v = b;
            if (p_masked)
               v = v ^ p_key[8 * (3 - p_key_idx) +: 8];
            p_key_idx   = p_key_idx + 2'd1;
            p_remaining = p_remaining - 64'd1;
            r = make_beat(KIND_PAYLOAD, p_fin, p_opcode, p_masked, p_length, v,
                          p_remaining == 64'd0);
            if (p_remaining == 64'd0)
               p_phase = PH_FIRST;
         end
         default: begin
            p_fin    = b[7];
            p_opcode = b[3:0];
            p_masked = 1'b0;
            p_length = '0;
            p_key    = '0;
            p_count  = '0;
            p_phase  = PH_SECOND;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin : beat_monitor
      deframe_beat_type got;
      deframe_beat_type want;
      deframe_beat_type pred;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = make_beat(rsp_item_kind, rsp_fin_flag, rsp_frame_opcode, rsp_masked_flag,
                            rsp_frame_length, rsp_payload_byte, rsp_frame_end);
            if (expected_beats.size() == 0) begin
               report_mismatch("result beat with nothing pending");
            end else begin
               want = expected_beats.pop_front();
               check_field("item_kind", got.kind, want.kind);
               check_field("fin_flag", got.fin, want.fin);
               check_field("frame_opcode", got.opcode, want.opcode);
               check_field("masked_flag", got.masked, want.masked);
               check_field("frame_length", got.length, want.length);
               check_field("payload_byte", got.data, want.data);
               check_field("frame_end", got.frame_end, want.frame_end);
            end
         end
         if (req_valid && req_ready) begin
            pred = deframe_byte(req_data_byte);
            expected_beats = {expected_beats, (cur_typed ? cur_exp : pred)};
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   always begin : result_sink
      int n;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready = 1'b0;
         n = $urandom_range(1, 12);
         repeat (n - 1) @(negedge clock);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Called just after a falling edge; returns just after the falling edge
   // that follows acceptance of the beat.
   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input deframe_beat_type e);
      int n;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         n = $urandom_range(1, 12);
         repeat (n) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      cur_typed     = typed;
      cur_exp       = e;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   logic [7:0]       dir_byte[$];
   bit               dir_typed[$];
   deframe_beat_type dir_exp[$];

   task automatic add_row(input logic [7:0] b, input bit typed, input deframe_beat_type e);
      dir_byte  = {dir_byte, b};
      dir_typed = {dir_typed, typed};
      dir_exp   = {dir_exp, e};
   endtask

   initial begin : stimulus
      logic [7:0]  first_byte;
      logic        msk;
      logic [6:0]  code;
      logic [63:0] len;
      int          sel;
      int          i;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      rsp_ready      = 1'b0;
      cur_typed      = 1'b0;
      cur_exp        = ABSORBED_BEAT;
      idle_on        = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      bytes_sent     = 0;

      // Unmasked zero-length frame straight after reset.
      add_row(8'h81, 1'b1, ABSORBED_BEAT);
      add_row(8'h00, 1'b1, make_beat(KIND_HEADER, 1'b1, 4'h1, 1'b0, 64'd0, 8'h00, 1'b1));
      // Masked zero-length frame: it ends on the last key byte.
      add_row(8'h0F, 1'b1, ABSORBED_BEAT);
      add_row(8'h80, 1'b1, ABSORBED_BEAT);
      add_row(8'h00, 1'b1, ABSORBED_BEAT);
      add_row(8'hFF, 1'b1, ABSORBED_BEAT);
      add_row(8'h12, 1'b1, ABSORBED_BEAT);
      add_row(8'h34, 1'b1, make_beat(KIND_HEADER, 1'b0, 4'hF, 1'b1, 64'd0, 8'h00, 1'b1));
      // Reserved bits set, non-minimal 16-bit length of 3, masked payload.
      add_row(8'h72, 1'b0, ABSORBED_BEAT);
      add_row(8'hFE, 1'b0, ABSORBED_BEAT);
      add_row(8'h00, 1'b0, ABSORBED_BEAT);
      add_row(8'h03, 1'b0, ABSORBED_BEAT);
      add_row(8'hA5, 1'b0, ABSORBED_BEAT);
      add_row(8'h5A, 1'b0, ABSORBED_BEAT);
      add_row(8'hFF, 1'b0, ABSORBED_BEAT);
      add_row(8'h00, 1'b0, ABSORBED_BEAT);
      add_row(8'hFF, 1'b0, ABSORBED_BEAT);
      add_row(8'h00, 1'b0, ABSORBED_BEAT);
      add_row(8'h3C, 1'b0, ABSORBED_BEAT);
      // Unmasked one-byte close frame.
      add_row(8'h88, 1'b0, ABSORBED_BEAT);
      add_row(8'h01, 1'b0, ABSORBED_BEAT);
      add_row(8'hAB, 1'b0, ABSORBED_BEAT);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset   = 1'b0;
      idle_on = 1'b1;

      for (i = 0; i < dir_byte.size(); i++)
         send_byte(dir_byte[i], dir_typed[i], dir_exp[i]);

      while (bytes_sent < RANDOM_ITEMS) begin
         if (bytes_sent >= RANDOM_ITEMS - CALM_ITEMS)
            idle_on = 1'b0;
         else
            idle_on = ($urandom_range(0, 3) != 0);
         first_byte = $urandom_range(0, 255);
         msk        = $urandom_range(0, 1);
         sel        = $urandom_range(0, 9);
         if (sel < 5) begin
            len  = $urandom_range(0, 12);
            code = len[6:0];
         end else if (sel == 5) begin
            len  = $urandom_range(0, 125);
            code = len[6:0];
         end else if (sel < 8) begin
            code = LEN16_CODE;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 40);
         end else begin
            code = LEN64_CODE;
            len  = $urandom_range(0, 30);
         end
         send_byte(first_byte, 1'b0, ABSORBED_BEAT);
         send_byte({msk, code}, 1'b0, ABSORBED_BEAT);
         if (code == LEN16_CODE) begin
            send_byte(len[15:8], 1'b0, ABSORBED_BEAT);
            send_byte(len[7:0], 1'b0, ABSORBED_BEAT);
         end else if (code == LEN64_CODE) begin
            for (i = 7; i >= 0; i--)
               send_byte(len[8 * i +: 8], 1'b0, ABSORBED_BEAT);
         end
         if (msk)
            repeat (4) send_byte($urandom_range(0, 255), 1'b0, ABSORBED_BEAT);
         repeat (len) send_byte($urandom_range(0, 255), 1'b0, ABSORBED_BEAT);
      end

      // A masked frame with the largest 64-bit length never ends, so it
      // closes the run: header, key and a few payload bytes.
      idle_on = 1'b0;
      send_byte(8'h8A, 1'b0, ABSORBED_BEAT);
      send_byte(8'hFF, 1'b0, ABSORBED_BEAT);
      repeat (8) send_byte(8'hFF, 1'b0, ABSORBED_BEAT);
      repeat (4) send_byte($urandom_range(0, 255), 1'b0, ABSORBED_BEAT);
      repeat (6) send_byte($urandom_range(0, 255), 1'b0, ABSORBED_BEAT);

      req_valid = 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
